// ===== hw/rtl/bracelet_count_polya_unit_assert.svh =====
// Assertion macros for the bracelet counter checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef BRACELET_COUNT_POLYA_UNIT_ASSERT_SVH
`define BRACELET_COUNT_POLYA_UNIT_ASSERT_SVH

// Same-cycle implication under asynchronous reset.
`define BCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous reset.
`define BCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication: the consequent is checked later than in the NXT form.
`define BCP_ASSERT_NXT2(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> ##1 (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bcp_pkg.sv =====
// Package for the bracelet counter: widths, microcode types and the control ROM.
// Depends on nothing; used by the interfaces, the divider, the top level and the checker.
package bcp_pkg;

	localparam int COLORS_W  = 8;
	localparam int BEADS_W   = 6;
	localparam int COUNT_W   = 64;
	localparam int MAX_BEADS = 32;
	localparam int MUL_W     = 8;
	localparam int PROD_W    = COUNT_W + MUL_W;
	localparam int EXP_W     = BEADS_W;
	localparam int DIVR_W    = BEADS_W + 1;
	localparam int DIV_STEPS = COUNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int UPC_W     = 5;

	typedef logic [UPC_W-1:0] upc_t;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_GCD_LD,
		OP_GCD_STEP,
		OP_PW_LD_GCD,
		OP_PW_LD_HALF,
		OP_PW_LD_HALF1,
		OP_PW_STEP,
		OP_PW_MUL_N,
		OP_PW_MUL_H,
		OP_SUM_ADD,
		OP_DIV_START,
		OP_FINISH
	} op_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_GCD_NE,
		C_E_NE1,
		C_I_LT_N,
		C_N_EVEN,
		C_OVF,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  tgt;
	} ucode_t;

	// Program step addresses
	localparam upc_t S_GCD_LD   = 5'd0;
	localparam upc_t S_GCD_RUN  = 5'd1;
	localparam upc_t S_POW_LD   = 5'd2;
	localparam upc_t S_POW_RUN  = 5'd3;
	localparam upc_t S_ROT_ADD  = 5'd4;
	localparam upc_t S_REF_LD   = 5'd5;
	localparam upc_t S_ODD_POW  = 5'd6;
	localparam upc_t S_ODD_MUL  = 5'd7;
	localparam upc_t S_ODD_ADD  = 5'd8;
	localparam upc_t S_EVN_POW1 = 5'd9;
	localparam upc_t S_EVN_MUL1 = 5'd10;
	localparam upc_t S_EVN_ADD1 = 5'd11;
	localparam upc_t S_EVN_LD2  = 5'd12;
	localparam upc_t S_EVN_POW2 = 5'd13;
	localparam upc_t S_EVN_MUL2 = 5'd14;
	localparam upc_t S_EVN_ADD2 = 5'd15;
	localparam upc_t S_OVF_CHK  = 5'd16;
	localparam upc_t S_DIV_GO   = 5'd17;
	localparam upc_t S_DIV_WAIT = 5'd18;
	localparam upc_t S_FINISH   = 5'd19;

	// Control program: rotation sum, reflection terms, then divide by 2n
	function automatic ucode_t ucode_rom(input upc_t addr);
		ucode_t w;
		unique case (addr)
			S_GCD_LD:   w = '{op: OP_GCD_LD,      cond: C_NEVER,    tgt: S_GCD_LD};
			S_GCD_RUN:  w = '{op: OP_GCD_STEP,    cond: C_GCD_NE,   tgt: S_GCD_RUN};
			S_POW_LD:   w = '{op: OP_PW_LD_GCD,   cond: C_NEVER,    tgt: S_GCD_LD};
			S_POW_RUN:  w = '{op: OP_PW_STEP,     cond: C_E_NE1,    tgt: S_POW_RUN};
			S_ROT_ADD:  w = '{op: OP_SUM_ADD,     cond: C_I_LT_N,   tgt: S_GCD_LD};
			S_REF_LD:   w = '{op: OP_PW_LD_HALF1, cond: C_N_EVEN,   tgt: S_EVN_POW1};
			S_ODD_POW:  w = '{op: OP_PW_STEP,     cond: C_E_NE1,    tgt: S_ODD_POW};
			S_ODD_MUL:  w = '{op: OP_PW_MUL_N,    cond: C_NEVER,    tgt: S_GCD_LD};
			S_ODD_ADD:  w = '{op: OP_SUM_ADD,     cond: C_ALWAYS,   tgt: S_OVF_CHK};
			S_EVN_POW1: w = '{op: OP_PW_STEP,     cond: C_E_NE1,    tgt: S_EVN_POW1};
			S_EVN_MUL1: w = '{op: OP_PW_MUL_H,    cond: C_NEVER,    tgt: S_GCD_LD};
			S_EVN_ADD1: w = '{op: OP_SUM_ADD,     cond: C_NEVER,    tgt: S_GCD_LD};
			S_EVN_LD2:  w = '{op: OP_PW_LD_HALF,  cond: C_NEVER,    tgt: S_GCD_LD};
			S_EVN_POW2: w = '{op: OP_PW_STEP,     cond: C_E_NE1,    tgt: S_EVN_POW2};
			S_EVN_MUL2: w = '{op: OP_PW_MUL_H,    cond: C_NEVER,    tgt: S_GCD_LD};
			S_EVN_ADD2: w = '{op: OP_SUM_ADD,     cond: C_NEVER,    tgt: S_GCD_LD};
			S_OVF_CHK:  w = '{op: OP_NOP,         cond: C_OVF,      tgt: S_FINISH};
			S_DIV_GO:   w = '{op: OP_DIV_START,   cond: C_NEVER,    tgt: S_GCD_LD};
			S_DIV_WAIT: w = '{op: OP_NOP,         cond: C_DIV_BUSY, tgt: S_DIV_WAIT};
			S_FINISH:   w = '{op: OP_FINISH,      cond: C_OUT_FULL, tgt: S_FINISH};
			default:    w = '{op: OP_NOP,         cond: C_ALWAYS,   tgt: S_FINISH};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/bcp_if.sv =====
// Valid/ready channel interfaces for the bracelet counter: request and response.
// Depends on bcp_pkg for field widths.
interface bcp_req_if;
	logic                         valid;
	logic                         ready;
	logic [bcp_pkg::COLORS_W-1:0] colors;
	logic [bcp_pkg::BEADS_W-1:0]  beads;

	modport source (output valid, output colors, output beads, input ready);
	modport sink (input valid, input colors, input beads, output ready);
endinterface

interface bcp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bcp_pkg::COUNT_W-1:0] count;
	logic                        overflow;
	logic                        invalid;

	modport source (output valid, output count, output overflow, output invalid, input ready);
	modport sink (input valid, input count, input overflow, input invalid, output ready);
endinterface

// ===== hw/rtl/bcp_div.sv =====
// Iterative restoring divider: 64-bit dividend by a 7-bit divisor, one bit per cycle.
// Depends on bcp_pkg for widths and step count.
module bcp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bcp_pkg::COUNT_W-1:0] dividend,
	input  logic [bcp_pkg::DIVR_W-1:0]  divisor,
	output logic                        busy,
	output logic [bcp_pkg::COUNT_W-1:0] quotient
);
	import bcp_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0]   dvd_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dsr_q;
	logic [DIVR_W:0]      trial;
	logic [DIVR_W:0]      diff;
	logic                 ge;

	// Trial subtract of the next remainder
	always_comb begin
		trial = {rem_q, dvd_q[COUNT_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	// Hold busy and the bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COUNT_W-2:0], ge};
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

// ===== hw/rtl/bracelet_count_polya_unit.sv =====
// Bracelet counter top level: microcoded sequencer over a 64x8 multiply/add datapath.
// Depends on bcp_pkg, bcp_if (bcp_req_if, bcp_rsp_if) and bcp_div.
//
//   channel | role   | payload
//   req     | sink   | colors[7:0], beads[5:0]
//   rsp     | source | count[63:0], overflow, invalid
//
// One request at a time; a new request is taken as soon as the previous one is
// parked in the response register. Work per request: per rotation a subtractive
// gcd, a power loop of gcd(i,n) multiplies and three overhead steps; then the
// reflection powers and a divide. A bad request (zero input or too many beads)
// goes straight to the finish step.
// Reset clears the sequencer, the divider and the response valid.
// A stalled response holds the sequencer in its last step until taken.
module bracelet_count_polya_unit (
	input  logic      clk,
	input  logic      arst_n,
	bcp_req_if.sink   req,
	bcp_rsp_if.source rsp
);
	import bcp_pkg::*;

	// Sequencer control
	logic busy_q;
	upc_t upc_q;
	ucode_t cw;
	logic jump;
	logic accept;
	logic in_bad;
	logic out_free;
	logic fin_fire;
	logic div_start;
	logic div_busy;
	logic [COUNT_W-1:0] div_quot;

	// Datapath
	logic [COLORS_W-1:0] k_q;
	logic [BEADS_W-1:0]  n_q;
	logic [BEADS_W-1:0]  i_q;
	logic [BEADS_W-1:0]  gx_q;
	logic [BEADS_W-1:0]  gy_q;
	logic [EXP_W-1:0]    e_q;
	logic [COUNT_W-1:0]  pw_q;
	logic [COUNT_W-1:0]  sum_q;
	logic                ovf_q;
	logic                inv_q;
	logic [MUL_W-1:0]    mul_m;
	logic [PROD_W-1:0]   prod;
	logic [COUNT_W:0]    sum_nx;

	// Response register
	logic               rsp_valid_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic               rsp_ovf_q;
	logic               rsp_inv_q;

	// Decode control word and jump condition
	always_comb begin
		cw       = ucode_rom(upc_q);
		out_free = !rsp_valid_q || rsp.ready;
		unique case (cw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_GCD_NE:   jump = gx_q != gy_q;
			C_E_NE1:    jump = e_q != EXP_W'(1);
			C_I_LT_N:   jump = i_q < n_q;
			C_N_EVEN:   jump = !n_q[0];
			C_OVF:      jump = ovf_q;
			C_DIV_BUSY: jump = div_busy;
			C_OUT_FULL: jump = !out_free;
			default:    jump = 1'b0;
		endcase
	end

	assign accept    = req.valid && !busy_q;
	assign in_bad    = (req.colors == '0) || (req.beads == '0)
		|| ({1'b0, req.beads} > DIVR_W'(MAX_BEADS));
	assign fin_fire  = busy_q && (cw.op == OP_FINISH) && out_free;
	assign div_start = busy_q && (cw.op == OP_DIV_START);

	// Shared multiplier operand and adder
	always_comb begin
		if (cw.op == OP_PW_MUL_N) begin
			mul_m = MUL_W'(n_q);
		end else if (cw.op == OP_PW_MUL_H) begin
			mul_m = MUL_W'(n_q[BEADS_W-1:1]);
		end else begin
			mul_m = k_q;
		end
		prod   = PROD_W'(pw_q) * PROD_W'(mul_m);
		sum_nx = {1'b0, sum_q} + {1'b0, pw_q};
	end

	// Advance the step counter; drop busy when the result is stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= S_GCD_LD;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				upc_q  <= in_bad ? S_FINISH : S_GCD_LD;
			end else if (busy_q) begin
				upc_q <= jump ? cw.tgt : upc_q + 1'b1;
				if (fin_fire) begin
					busy_q <= 1'b0;
				end
			end
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Execute the datapath operation of the current step
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q   <= req.colors;
			n_q   <= req.beads;
			i_q   <= BEADS_W'(1);
			sum_q <= '0;
			ovf_q <= 1'b0;
			inv_q <= in_bad;
		end else if (busy_q) begin
			unique case (cw.op)
				OP_GCD_LD: begin
					gx_q <= i_q;
					gy_q <= n_q;
				end
				OP_GCD_STEP: begin
					if (gx_q > gy_q) begin
						gx_q <= gx_q - gy_q;
					end else if (gy_q > gx_q) begin
						gy_q <= gy_q - gx_q;
					end
				end
				OP_PW_LD_GCD: begin
					pw_q <= COUNT_W'(1);
					e_q  <= gx_q;
				end
				OP_PW_LD_HALF: begin
					pw_q <= COUNT_W'(1);
					e_q  <= EXP_W'(n_q[BEADS_W-1:1]);
				end
				OP_PW_LD_HALF1: begin
					pw_q <= COUNT_W'(1);
					e_q  <= EXP_W'(n_q[BEADS_W-1:1]) + EXP_W'(1);
				end
				OP_PW_STEP, OP_PW_MUL_N, OP_PW_MUL_H: begin
					pw_q <= prod[COUNT_W-1:0];
					if (prod[PROD_W-1:COUNT_W] != '0) begin
						ovf_q <= 1'b1;
					end
					if (cw.op == OP_PW_STEP) begin
						e_q <= e_q - EXP_W'(1);
					end
				end
				OP_SUM_ADD: begin
					sum_q <= sum_nx[COUNT_W-1:0];
					i_q   <= i_q + BEADS_W'(1);
					if (sum_nx[COUNT_W]) begin
						ovf_q <= 1'b1;
					end
				end
				OP_NOP, OP_DIV_START, OP_FINISH: begin
				end
				default: begin
				end
			endcase
		end
		if (fin_fire) begin
			rsp_count_q <= (ovf_q || inv_q) ? '0 : div_quot;
			rsp_ovf_q   <= ovf_q && !inv_q;
			rsp_inv_q   <= inv_q;
		end
	end

	// Divide the total by twice the bead count
	bcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  ({n_q, 1'b0}),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign req.ready    = !busy_q;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.overflow = rsp_ovf_q;
	assign rsp.invalid  = rsp_inv_q;

endmodule

// ===== hw/rtl/bcp_chk.sv =====
// Port-level checker for the bracelet counter, bound to the top level.
// Depends on bracelet_count_polya_unit_assert.svh and bcp_pkg.
`include "bracelet_count_polya_unit_assert.svh"

module bcp_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [bcp_pkg::COLORS_W-1:0] req_colors,
	input logic [bcp_pkg::BEADS_W-1:0]  req_beads,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bcp_pkg::COUNT_W-1:0]  rsp_count,
	input logic                         rsp_overflow,
	input logic                         rsp_invalid
);
	import bcp_pkg::*;

	// Flagged results carry no count
	`BCP_ASSERT_NOW(a_inv_clean, clk, arst_n, rsp_valid && rsp_invalid, (rsp_count == '0) && !rsp_overflow, "invalid result with count or overflow set")
	`BCP_ASSERT_NOW(a_ovf_clean, clk, arst_n, rsp_valid && rsp_overflow, rsp_count == '0, "overflow result with nonzero count")

	// A taken request drops ready in the cycle after it
	`BCP_ASSERT_NXT(a_busy_after, clk, arst_n, req_valid && req_ready, !req_ready, "request taken back to back")

	// Bad requests skip the computation
	`BCP_ASSERT_NXT2(a_bad_fast, clk, arst_n, req_valid && req_ready && !rsp_valid && ((req_colors == '0) || (req_beads == '0) || (req_beads > BEADS_W'(MAX_BEADS))), rsp_valid && rsp_invalid, "bad request not flagged on the fast path")

	// Stalled response holds
	`BCP_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count) && $stable(rsp_overflow) && $stable(rsp_invalid), "stalled response changed")

endmodule

bind bracelet_count_polya_unit bcp_chk u_bcp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_colors   (req.colors),
	.req_beads    (req.beads),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_count    (rsp.count),
	.rsp_overflow (rsp.overflow),
	.rsp_invalid  (rsp.invalid)
);
